### sv/adcavg_pkg.sv
// ----------------------------------------------------------------------------
// adcavg_pkg
// shared types and constants for the converter averaging block
// ----------------------------------------------------------------------------
package adcavg_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CH_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int PCT_W      = 7;
    localparam int MEANS_N    = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    // status codes of a result word
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [PCT_W-1:0]    PERCENT_SPAN = 7'd100;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // control token that travels with each word through the pipeline
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CH_W-1:0]     next_channel;
        logic                discard_next;
        logic                start;
        logic                fail;
        logic                ch_done;
        logic [CH_W-1:0]     ch_idx;
        logic                last;
    } ctl_t;

endpackage

### sv/multichannel_adc_average_to_percent_core.sv
// ----------------------------------------------------------------------------
// multichannel_adc_average_to_percent_core
// multichannel converter averaging sequencer with inverse percent map
// ----------------------------------------------------------------------------
// usage:
//   input words (s_ group) carry a start command (tuser = 0) or one
//   conversion result (tuser = 1) with its sample and ok flag. every input
//   word yields exactly one output word (m_ group) with the run status, the
//   channel to sample next, whether that read is the settling read, and the
//   averaged values, which read zero unless the last run finished ok.
// path: an accepted input word passes the input register, then sequencer,
//   channel mean, overall mean and result register before its result
//   shows on m_tvalid
// throughput: one word per cycle; the pipeline moves as a whole and only
//   holds when the result register is full and m_tready is low
// stall: while m_tready is low with a result waiting, s_tready drops in the
//   same cycle and every stage keeps its word; nothing is lost or repeated
// reset: rst_n clears the run, counters, means and the valid flag; no run is
//   active, so conversions before a start come back as ignored
// ----------------------------------------------------------------------------
module multichannel_adc_average_to_percent_core #(
    parameter int SAMPLES_PER_CHANNEL = 5,
    parameter int CHANNEL_COUNT       = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adcavg_pkg::IN_DATA_W-1:0]  s_tdata,   // sample[11:0], conversion_ok[12]
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adcavg_pkg::OUT_DATA_W-1:0] m_tdata,   // next_channel[1:0], discard_next[2],
                                                         // valid_res[3], moisture_percent[10:4],
                                                         // raw_average[22:11], raw_first[34:23],
                                                         // raw_second[46:35], raw_third[58:47]
    output logic [adcavg_pkg::STATUS_W-1:0]   m_tuser    // status
);

    localparam int SUM_W = $clog2(SAMPLES_PER_CHANNEL * 4095 + 1);
    localparam int SW    = adcavg_pkg::SAMPLE_W;

    // whole pipeline advances together unless a result is held back
    logic                 en;

    // input register
    logic                 in_valid_reg;
    logic                 mode_reg;
    adcavg_pkg::sample_t  sample_reg;
    logic                 ok_reg;

    // sequencer to mean stage
    logic                 tok_valid;
    adcavg_pkg::ctl_t     tok;
    logic [SUM_W-1:0]     sum;

    // mean stage to result stage
    logic                 avg_valid;
    adcavg_pkg::ctl_t     avg_tok;
    adcavg_pkg::sample_t  avg_mean;
    adcavg_pkg::sample_t  avg_overall;
    adcavg_pkg::sample_t  avg_diff;

    // result fields
    logic                                 out_valid;
    logic [adcavg_pkg::STATUS_W-1:0]      status;
    logic [adcavg_pkg::CH_W-1:0]          next_channel;
    logic                                 discard_next;
    logic                                 valid_res;
    logic [adcavg_pkg::PCT_W-1:0]         moisture_percent;
    adcavg_pkg::sample_t                  raw_average;
    adcavg_pkg::sample_t                  raw_first;
    adcavg_pkg::sample_t                  raw_second;
    adcavg_pkg::sample_t                  raw_third;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en && s_tvalid)
        begin
            mode_reg   <= s_tuser;
            sample_reg <= s_tdata[SW-1:0];
            ok_reg     <= s_tdata[SW];
        end
    end

    adcavg_seq #(
        .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
        .CHANNEL_COUNT       (CHANNEL_COUNT),
        .SUM_W               (SUM_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid_reg),
        .mode          (mode_reg),
        .sample        (sample_reg),
        .conversion_ok (ok_reg),
        .tok_valid     (tok_valid),
        .tok           (tok),
        .sum           (sum)
    );

    adcavg_mean #(
        .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
        .CHANNEL_COUNT       (CHANNEL_COUNT),
        .SUM_W               (SUM_W)
    ) u_mean (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .sum         (sum),
        .avg_valid   (avg_valid),
        .avg_tok     (avg_tok),
        .avg_mean    (avg_mean),
        .avg_overall (avg_overall),
        .avg_diff    (avg_diff)
    );

    adcavg_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .avg_valid        (avg_valid),
        .avg_tok          (avg_tok),
        .avg_mean         (avg_mean),
        .avg_overall      (avg_overall),
        .avg_diff         (avg_diff),
        .out_valid        (out_valid),
        .status           (status),
        .next_channel     (next_channel),
        .discard_next     (discard_next),
        .valid_res        (valid_res),
        .moisture_percent (moisture_percent),
        .raw_average      (raw_average),
        .raw_first        (raw_first),
        .raw_second       (raw_second),
        .raw_third        (raw_third)
    );

    // output word packing, lowest field first, zero pad to 64 bits
    assign m_tvalid = out_valid;
    assign m_tuser  = status;
    assign m_tdata  = {5'd0, raw_third, raw_second, raw_first, raw_average,
                       moisture_percent, valid_res, discard_next, next_channel};

endmodule

### sv/adcavg_seq.sv
// ----------------------------------------------------------------------------
// adcavg_seq
// run sequencer: channel and sample counters, per-channel sample sum
// ----------------------------------------------------------------------------
module adcavg_seq #(
    parameter int SAMPLES_PER_CHANNEL = 5,
    parameter int CHANNEL_COUNT       = 3,
    parameter int SUM_W               = $clog2(SAMPLES_PER_CHANNEL * 4095 + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     mode,
    input  adcavg_pkg::sample_t      sample,
    input  logic                     conversion_ok,
    output logic                     tok_valid,
    output adcavg_pkg::ctl_t         tok,
    output logic [SUM_W-1:0]         sum
);

    localparam int SIDX_W = $clog2(SAMPLES_PER_CHANNEL + 2);
    localparam int CH_W   = adcavg_pkg::CH_W;

    logic                  running_reg, running_next;
    logic [CH_W-1:0]       ch_reg, ch_next;
    logic [SIDX_W-1:0]     sidx_reg, sidx_next;
    logic [SUM_W-1:0]      sacc_reg, sacc_next;
    logic                  tok_valid_reg;
    adcavg_pkg::ctl_t      tok_reg, tok_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUM_W-1:0]      sacc_add;
    logic [CH_W-1:0]       ch_inc;

    assign sacc_add = sacc_reg + SUM_W'(sample);
    assign ch_inc   = ch_reg + CH_W'(1);

    always_comb
    begin
        running_next = running_reg;
        ch_next      = ch_reg;
        sidx_next    = sidx_reg;
        sacc_next    = sacc_reg;
        sum_next     = sacc_add;
        tok_next     = '0;
        tok_next.status = adcavg_pkg::ST_BUSY;
        tok_next.ch_idx = ch_reg;

        if (!mode)
        begin
            running_next   = 1'b1;
            ch_next        = '0;
            sidx_next      = '0;
            sacc_next      = '0;
            tok_next.start = 1'b1;
        end
        else if (!running_reg)
        begin
            tok_next.status = adcavg_pkg::ST_IGNORED;
        end
        else if (sidx_reg == '0)
        begin
            // settling read, dropped whatever its outcome
            sidx_next = SIDX_W'(1);
        end
        else if (!conversion_ok)
        begin
            running_next    = 1'b0;
            tok_next.fail   = 1'b1;
            tok_next.status = adcavg_pkg::ST_FAIL;
        end
        else if (sidx_reg == SIDX_W'(SAMPLES_PER_CHANNEL))
        begin
            // last counted read of this channel
            tok_next.ch_done = 1'b1;
            sidx_next        = '0;
            sacc_next        = '0;
            ch_next          = ch_inc;
            if (ch_inc >= CH_W'(CHANNEL_COUNT))
            begin
                tok_next.last   = 1'b1;
                tok_next.status = adcavg_pkg::ST_DONE;
                running_next    = 1'b0;
                ch_next         = '0;
            end
        end
        else
        begin
            sacc_next = sacc_add;
            sidx_next = sidx_reg + SIDX_W'(1);
        end

        tok_next.next_channel = running_next ? ch_next : '0;
        tok_next.discard_next = running_next && (sidx_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            ch_reg        <= '0;
            sidx_reg      <= '0;
            sacc_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tok_valid_reg <= in_valid;
            if (in_valid)
            begin
                running_reg <= running_next;
                ch_reg      <= ch_next;
                sidx_reg    <= sidx_next;
                sacc_reg    <= sacc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            tok_reg <= tok_next;
            sum_reg <= sum_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;
    assign sum       = sum_reg;

endmodule

### sv/adcavg_mean.sv
// ----------------------------------------------------------------------------
// adcavg_mean
// channel mean, channel sum and overall mean by reciprocal multiplication
// ----------------------------------------------------------------------------
module adcavg_mean #(
    parameter int SAMPLES_PER_CHANNEL = 5,
    parameter int CHANNEL_COUNT       = 3,
    parameter int SUM_W               = $clog2(SAMPLES_PER_CHANNEL * 4095 + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 tok_valid,
    input  adcavg_pkg::ctl_t     tok,
    input  logic [SUM_W-1:0]     sum,
    output logic                 avg_valid,
    output adcavg_pkg::ctl_t     avg_tok,
    output adcavg_pkg::sample_t  avg_mean,
    output adcavg_pkg::sample_t  avg_overall,
    output adcavg_pkg::sample_t  avg_diff
);

    localparam int SW     = adcavg_pkg::SAMPLE_W;
    // floor(x / d) = (x * ceil(2^s / d)) >> s, exact for x below 2^(s-5), d up to 32
    localparam int SH1    = SUM_W + 5;
    localparam int REC1_W = SH1 + 1;
    localparam logic [REC1_W-1:0] REC1 = REC1_W'(((longint'(1) << SH1)
                                         + longint'(SAMPLES_PER_CHANNEL) - 1)
                                         / longint'(SAMPLES_PER_CHANNEL));
    localparam int ACC_W  = $clog2(CHANNEL_COUNT * 4095 + 1);
    localparam int SH2    = ACC_W + 5;
    localparam int REC2_W = SH2 + 1;
    localparam logic [REC2_W-1:0] REC2 = REC2_W'(((longint'(1) << SH2)
                                         + longint'(CHANNEL_COUNT) - 1)
                                         / longint'(CHANNEL_COUNT));

    logic [SUM_W+REC1_W-1:0] prod1;
    logic [ACC_W+REC2_W-1:0] prod2;
    logic [SW-1:0]           mean_c;
    logic [SW-1:0]           overall_c;
    logic [ACC_W-1:0]        acc_reg, acc_next;

    logic                    v2_reg;
    adcavg_pkg::ctl_t        tok2_reg;
    logic [SW-1:0]           mean2_reg;

    logic                    v3_reg;
    adcavg_pkg::ctl_t        tok3_reg;
    logic [SW-1:0]           mean3_reg;
    logic [SW-1:0]           overall3_reg;
    logic [SW-1:0]           diff3_reg;

    // first stage: channel mean and running channel sum
    assign prod1  = (SUM_W+REC1_W)'(sum) * (SUM_W+REC1_W)'(REC1);
    assign mean_c = prod1[SH1 +: SW];

    always_comb
    begin
        acc_next = acc_reg;
        if (tok.start)
            acc_next = '0;
        else if (tok.ch_done)
            acc_next = acc_reg + ACC_W'(mean_c);
    end

    // second stage: mean of channel means and its distance from full scale
    assign prod2     = (ACC_W+REC2_W)'(acc_reg) * (ACC_W+REC2_W)'(REC2);
    assign overall_c = prod2[SH2 +: SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= tok_valid;
            v3_reg <= v2_reg;
            if (tok_valid)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (tok_valid)
            begin
                tok2_reg  <= tok;
                mean2_reg <= mean_c;
            end
            if (v2_reg)
            begin
                tok3_reg     <= tok2_reg;
                mean3_reg    <= mean2_reg;
                overall3_reg <= overall_c;
                diff3_reg    <= adcavg_pkg::FULL_SCALE - overall_c;
            end
        end
    end

    assign avg_valid   = v3_reg;
    assign avg_tok     = tok3_reg;
    assign avg_mean    = mean3_reg;
    assign avg_overall = overall3_reg;
    assign avg_diff    = diff3_reg;

endmodule

### sv/adcavg_out.sv
// ----------------------------------------------------------------------------
// adcavg_out
// percent map, result registers and valid flag
// ----------------------------------------------------------------------------
module adcavg_out (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    avg_valid,
    input  adcavg_pkg::ctl_t                        avg_tok,
    input  adcavg_pkg::sample_t                     avg_mean,
    input  adcavg_pkg::sample_t                     avg_overall,
    input  adcavg_pkg::sample_t                     avg_diff,
    output logic                                    out_valid,
    output logic [adcavg_pkg::STATUS_W-1:0]         status,
    output logic [adcavg_pkg::CH_W-1:0]             next_channel,
    output logic                                    discard_next,
    output logic                                    valid_res,
    output logic [adcavg_pkg::PCT_W-1:0]            moisture_percent,
    output adcavg_pkg::sample_t                     raw_average,
    output adcavg_pkg::sample_t                     raw_first,
    output adcavg_pkg::sample_t                     raw_second,
    output adcavg_pkg::sample_t                     raw_third
);

    localparam int PW = adcavg_pkg::PCT_W;
    localparam int XW = 20;

    logic [XW-1:0]                 scaled;
    logic [XW-1:0]                 quot;
    logic [PW-1:0]                 pct_c;

    logic                          out_valid_reg;
    adcavg_pkg::ctl_t              ctl_reg;
    logic                          valid_reg;
    logic [PW-1:0]                 pct_reg;
    adcavg_pkg::sample_t           overall_reg;
    adcavg_pkg::sample_t           means_reg [adcavg_pkg::MEANS_N];

    // x / 4095 = (x + (x >> 12) + 1) >> 12 for x below 4095 * 4096
    assign scaled = XW'(avg_diff) * XW'(adcavg_pkg::PERCENT_SPAN);
    assign quot   = (scaled + (scaled >> 12) + XW'(1)) >> 12;
    assign pct_c  = quot[PW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ctl_reg       <= '0;
            valid_reg     <= 1'b0;
            pct_reg       <= '0;
            overall_reg   <= '0;
            for (int i = 0; i < adcavg_pkg::MEANS_N; i++)
                means_reg[i] <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= avg_valid;
            if (avg_valid)
            begin
                ctl_reg <= avg_tok;
                if (avg_tok.start || avg_tok.fail)
                    valid_reg <= 1'b0;
                if (avg_tok.ch_done)
                    means_reg[avg_tok.ch_idx] <= avg_mean;
                if (avg_tok.last)
                begin
                    overall_reg <= avg_overall;
                    pct_reg     <= pct_c;
                    valid_reg   <= 1'b1;
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = ctl_reg.status;
    assign next_channel     = ctl_reg.next_channel;
    assign discard_next     = ctl_reg.discard_next;
    assign valid_res        = valid_reg;
    assign moisture_percent = valid_reg ? pct_reg : '0;
    assign raw_average      = valid_reg ? overall_reg : '0;
    assign raw_first        = valid_reg ? means_reg[0] : '0;
    assign raw_second       = valid_reg ? means_reg[1] : '0;
    assign raw_third        = valid_reg ? means_reg[2] : '0;

endmodule

### sv/adcavg_chk.sv
// ----------------------------------------------------------------------------
// adcavg_chk
// port-level checks for the converter averaging block
// ----------------------------------------------------------------------------
module adcavg_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [adcavg_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [adcavg_pkg::STATUS_W-1:0]   m_tuser
);

    // a held result word stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // values read zero while the valid flag is clear
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[58:4] == '0)
        else $error("value fields nonzero with valid clear");

    // finished run sets valid, failed run clears it
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != adcavg_pkg::ST_DONE || m_tdata[3])
                  && (m_tuser != adcavg_pkg::ST_FAIL || !m_tdata[3]))
        else $error("valid flag disagrees with status");

    // with no run active there is no channel to sample and no settling read
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == adcavg_pkg::ST_IGNORED || m_tuser == adcavg_pkg::ST_DONE
                     || m_tuser == adcavg_pkg::ST_FAIL) |-> m_tdata[2:0] == '0)
        else $error("channel or settling flag set with no run active");

    // percent never exceeds full span
    a_pct: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:4] <= adcavg_pkg::PERCENT_SPAN)
        else $error("percent out of range");

endmodule

bind multichannel_adc_average_to_percent_core adcavg_chk u_adcavg_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
